// ===== hdl/assert_macros.svh =====
// Assertion helpers for the stack-sortable prefix checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define SSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssp assertion failed");

// Next-cycle implication, idle during reset.
`define SSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssp assertion failed");

`endif

// ===== hdl/ssp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stack-sortable prefix checker.
// No dependencies; every other file but assert_macros.svh imports it.
package ssp_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int VALUE_BITS  = 16;
  localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
  localparam int PTR_BITS    = 11;
  localparam int ELEM_BITS   = 16;
  localparam int EXP_BITS    = 17;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ORDER    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } ssp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_RD_WAIT,
    ST_CHK,
    ST_OUT
  } ssp_state_t;

  typedef enum logic {
    CMP_EQ,
    CMP_GT
  } ssp_cmp_op_t;

  typedef struct packed {
    ssp_cmp_op_t         op;
    logic [EXP_BITS-1:0] a;
    logic [EXP_BITS-1:0] b;
  } ssp_cmp_req_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic                  re;
    logic [ADDR_BITS-1:0]  raddr;
  } ssp_mem_req_t;

endpackage

// ===== hdl/ssp_cmp.sv =====
`timescale 1ns / 1ps
// Shared compare unit: equality for the pop test, greater-than for the order check.
// Depends on ssp_pkg.
module ssp_cmp (
  input  ssp_pkg::ssp_cmp_req_t req,
  output logic                  hit
);
  import ssp_pkg::*;

  always_comb begin
    case (req.op)
      CMP_EQ:  hit = (req.a == req.b);
      CMP_GT:  hit = (req.a > req.b);
      default: hit = 1'b0;
    endcase
  end

endmodule

// ===== hdl/ssp_stack_mem.sv =====
`timescale 1ns / 1ps
// Stack storage: one write port, one read port with registered read data.
// Depends on ssp_pkg.
module ssp_stack_mem (
  input  logic                           clk,
  input  ssp_pkg::ssp_mem_req_t          req,
  output logic [ssp_pkg::VALUE_BITS-1:0] rdata
);
  import ssp_pkg::*;

  logic [VALUE_BITS-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== hdl/stack_sortable_prefix_checker.sv =====
`timescale 1ns / 1ps
// Stack-sortable prefix checker: push each element, pop matches, check order.
// Depends on ssp_pkg, ssp_cmp and ssp_stack_mem.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one prefix element per word with
//   start_new, which clears stack, status and expected value first, and
//   last_of_prefix, echoed as out_final_res. Output channel
//   (out_valid/out_ready) returns one word per input word: sticky status,
//   next expected value and current stack depth.
//   Sequence: an accepted element is pushed; the pop loop in ST_POP, which
//   shares one compare unit, waits in ST_RD_WAIT for the registered stack
//   read after each pop that leaves entries; if it stops with two or more
//   entries, ST_CHK runs the order check; then ST_OUT. An item after a
//   failure or at a full stack goes straight to ST_OUT. in_ready is low
//   while an item is in work; it rises as the output register is loaded.
//   Reset clears state, stack pointer, status, expected value and out_valid; the
//   stack memory needs no clearing because only entries below the pointer
//   are read. A stalled receiver holds the output word; the block finishes
//   the next item and then waits until the output register frees.
module stack_sortable_prefix_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ssp_pkg::ELEM_BITS-1:0]  in_element,
  input  logic                           in_start_new,
  input  logic                           in_last_of_prefix,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [ssp_pkg::EXP_BITS-1:0]   out_next_expected,
  output logic [ssp_pkg::PTR_BITS-1:0]   out_stack_depth,
  output logic                           out_final_res
);
  import ssp_pkg::*;

  localparam logic [PTR_BITS-1:0] DEPTH_PTR = PTR_BITS'(STACK_DEPTH);

  ssp_state_t            state_r, state_nxt;
  logic [PTR_BITS-1:0]   sp_r, sp_nxt;
  logic [EXP_BITS-1:0]   exp_r, exp_nxt;
  ssp_status_t           fail_r, fail_nxt;
  logic [VALUE_BITS-1:0] top_r, top_nxt;
  logic                  last_r, last_nxt;

  logic                  out_valid_r, out_valid_nxt;
  ssp_status_t           out_status_r, out_status_nxt;
  logic [EXP_BITS-1:0]   out_exp_r, out_exp_nxt;
  logic [PTR_BITS-1:0]   out_sp_r, out_sp_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [PTR_BITS-1:0]   base_sp;
  logic [EXP_BITS-1:0]   base_exp;
  ssp_status_t           base_fail;
  logic [PTR_BITS-1:0]   sp_below;

  ssp_cmp_req_t          cmp_req;
  logic                  cmp_hit;
  ssp_mem_req_t          mem_req;
  logic [VALUE_BITS-1:0] mem_rdata;

  ssp_cmp u_cmp (
    .req (cmp_req),
    .hit (cmp_hit)
  );

  ssp_stack_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign base_sp   = in_start_new ? '0 : sp_r;
  assign base_exp  = in_start_new ? EXP_BITS'(1) : exp_r;
  assign base_fail = in_start_new ? STATUS_OK : fail_r;
  assign sp_below  = sp_r - PTR_BITS'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sp_r        <= '0;
      exp_r       <= EXP_BITS'(1);
      fail_r      <= STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      exp_r       <= exp_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    last_r       <= last_nxt;
    out_status_r <= out_status_nxt;
    out_exp_r    <= out_exp_nxt;
    out_sp_r     <= out_sp_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    exp_nxt        = exp_r;
    fail_nxt       = fail_r;
    top_nxt        = top_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_exp_nxt    = out_exp_r;
    out_sp_nxt     = out_sp_r;
    out_last_nxt   = out_last_r;
    cmp_req.op     = CMP_EQ;
    cmp_req.a      = {1'b0, top_r};
    cmp_req.b      = exp_r;
    mem_req.we     = 1'b0;
    mem_req.waddr  = base_sp[ADDR_BITS-1:0];
    mem_req.wdata  = in_element[VALUE_BITS-1:0];
    mem_req.re     = 1'b0;
    mem_req.raddr  = sp_below[ADDR_BITS-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sp_nxt   = base_sp;
          exp_nxt  = base_exp;
          fail_nxt = base_fail;
          last_nxt = in_last_of_prefix;
          if (base_fail != STATUS_OK) begin
            state_nxt = ST_OUT;
          end else if (base_sp == DEPTH_PTR) begin
            // drop the word, stack is full
            fail_nxt  = STATUS_OVERFLOW;
            state_nxt = ST_OUT;
          end else begin
            mem_req.we = 1'b1;
            sp_nxt     = base_sp + PTR_BITS'(1);
            top_nxt    = in_element[VALUE_BITS-1:0];
            state_nxt  = ST_POP;
          end
        end
      end
      ST_POP: begin
        // top_r always mirrors the entry at sp_r - 1 here
        if (cmp_hit) begin
          sp_nxt  = sp_r - PTR_BITS'(1);
          exp_nxt = exp_r + EXP_BITS'(1);
        end
        if (sp_r >= PTR_BITS'(2)) begin
          mem_req.re = 1'b1;
          state_nxt  = cmp_hit ? ST_RD_WAIT : ST_CHK;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_RD_WAIT: begin
        top_nxt   = mem_rdata;
        state_nxt = ST_POP;
      end
      ST_CHK: begin
        cmp_req.op = CMP_GT;
        cmp_req.b  = {1'b0, mem_rdata};
        if (cmp_hit) begin
          fail_nxt = STATUS_ORDER;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fail_r;
          out_exp_nxt    = exp_r;
          out_sp_nxt     = sp_r;
          out_last_nxt   = last_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_next_expected = out_exp_r;
  assign out_stack_depth   = out_sp_r;
  assign out_final_res     = out_last_r;

endmodule

// ===== hdl/ssp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the stack-sortable prefix checker, bound to the top level.
// Depends on ssp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ssp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     out_status,
  input logic [ssp_pkg::EXP_BITS-1:0]   out_next_expected,
  input logic [ssp_pkg::PTR_BITS-1:0]   out_stack_depth,
  input logic                           out_final_res
);
  import ssp_pkg::*;

  // an accepted word drops in_ready in the next cycle
  `SSP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a stalled result word holds
  `SSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_next_expected) &&
    $stable(out_stack_depth) && $stable(out_final_res))

  `SSP_ASSERT_NOW(a_depth_bound, out_valid, out_stack_depth <= PTR_BITS'(STACK_DEPTH))

  `SSP_ASSERT_NOW(a_expected_nonzero, out_valid, out_next_expected != '0)

endmodule

bind stack_sortable_prefix_checker ssp_checker u_ssp_checker (.*);

// ===== tb/sv/ssp_verdict_check.sv =====
`timescale 1ns / 1ps
// Watches the input and result channels of the stack-sortable prefix checker.
// It predicts each result word and compares it with the block's output.
// Depends on ssp_pkg; the top reads its mismatch and pending counts.
module ssp_verdict_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [ssp_pkg::ELEM_BITS-1:0] in_element,
  input  logic                         in_start_new,
  input  logic                         in_last_of_prefix,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [1:0]                   out_status,
  input  logic [ssp_pkg::EXP_BITS-1:0] out_next_expected,
  input  logic [ssp_pkg::PTR_BITS-1:0] out_stack_depth,
  input  logic                         out_final_res,
  output int                           mismatch_total,
  output int                           words_pending
);
  import ssp_pkg::*;

  typedef struct packed {
    ssp_status_t         status;
    logic [EXP_BITS-1:0] next_exp;
    logic [PTR_BITS-1:0] depth;
    logic                final_res;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [VALUE_BITS-1:0] stack_mem [STACK_DEPTH];
  int unsigned           stack_cnt;
  logic [EXP_BITS-1:0]   want_next;
  ssp_status_t           sticky;
  int                    bad_words;

  // Push one element, pop every match, check the top pair; returns the word.
  function automatic verdict_t push_and_check(logic [ELEM_BITS-1:0] elem, logic first,
                                              logic fin);
    verdict_t v;
    if (first) begin
      stack_cnt = 0;
      want_next = EXP_BITS'(1);
      sticky    = STATUS_OK;
    end
    if (sticky == STATUS_OK) begin
      if (stack_cnt >= STACK_DEPTH) begin
        sticky = STATUS_OVERFLOW;
      end else begin
        stack_mem[stack_cnt] = elem[VALUE_BITS-1:0];
        stack_cnt++;
        while (stack_cnt > 0 && stack_mem[stack_cnt-1] == want_next) begin
          stack_cnt--;
          want_next++;
        end
        if (stack_cnt >= 2 && stack_mem[stack_cnt-1] > stack_mem[stack_cnt-2])
          sticky = STATUS_ORDER;
      end
    end
    v.status    = sticky;
    v.next_exp  = want_next;
    v.depth     = stack_cnt[PTR_BITS-1:0];
    v.final_res = fin;
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    if (!rst_n) begin
      verdict_q.delete();
      stack_cnt = 0;
      want_next = EXP_BITS'(1);
      sticky    = STATUS_OK;
      bad_words = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("check: unexpected word status %0d next %0d depth %0d final %0d",
                     out_status, out_next_expected, out_stack_depth, out_final_res);
        end else begin
          want = verdict_q.pop_front();
          if (out_status !== want.status || out_next_expected !== want.next_exp ||
              out_stack_depth !== want.depth || out_final_res !== want.final_res) begin
            bad_words++;
            if (bad_words <= 10)
              $display({"check: mismatch (exp/got) status %0d/%0d next %0d/%0d",
                        " depth %0d/%0d final %0d/%0d"},
                       want.status, out_status, want.next_exp, out_next_expected,
                       want.depth, out_stack_depth, want.final_res, out_final_res);
          end
        end
      end
      if (in_valid && in_ready)
        verdict_q.push_back(push_and_check(in_element, in_start_new, in_last_of_prefix));
    end
    // hand over with nonblocking updates so the top samples settled values
    mismatch_total <= bad_words;
    words_pending  <= verdict_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Top of the stack-sortable prefix checker testbench: clock, reset, stimulus,
// receiver stalls and verdict. Depends on ssp_pkg, the block and ssp_verdict_check.
module tb;
  import ssp_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ELEM_BITS-1:0] in_element;
  logic                in_start_new;
  logic                in_last_of_prefix;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_status;
  logic [EXP_BITS-1:0] out_next_expected;
  logic [PTR_BITS-1:0] out_stack_depth;
  logic                out_final_res;

  int          mismatches;
  int          pending;
  bit          burst_mode;
  int unsigned words_sent;
  int unsigned perm_q[$];

  stack_sortable_prefix_checker DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_element        (in_element),
    .in_start_new      (in_start_new),
    .in_last_of_prefix (in_last_of_prefix),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_next_expected (out_next_expected),
    .out_stack_depth   (out_stack_depth),
    .out_final_res     (out_final_res)
  );

  ssp_verdict_check u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_element        (in_element),
    .in_start_new      (in_start_new),
    .in_last_of_prefix (in_last_of_prefix),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_next_expected (out_next_expected),
    .out_stack_depth   (out_stack_depth),
    .out_final_res     (out_final_res),
    .mismatch_total    (mismatches),
    .words_pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned send_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // Called just after the clock rises; returns in the time step in which the block accepts the word.
  task automatic send_word(input int unsigned elem, input bit first, input bit fin);
    int unsigned gap;
    gap = send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_element        <= elem[ELEM_BITS-1:0];
    in_start_new      <= first;
    in_last_of_prefix <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Values lo..hi with hi placed so that everything before it is below
  // everything after it: such orders avoid the 231 pattern and sort cleanly.
  task automatic build_sortable(input int lo, input int hi);
    int split;
    if (lo > hi) return;
    split = $urandom_range(lo, hi);
    build_sortable(lo, split - 1);
    perm_q.push_back(hi);
    build_sortable(split, hi - 1);
  endtask

  task automatic build_shuffled(input int n);
    int j;
    int unsigned t;
    perm_q.delete();
    for (int i = 1; i <= n; i++) perm_q.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      j         = $urandom_range(0, i);
      t         = perm_q[i];
      perm_q[i] = perm_q[j];
      perm_q[j] = t;
    end
  endtask

  task automatic send_perm(input bit fresh, input bit ends);
    for (int i = 0; i < perm_q.size(); i++)
      send_word(perm_q[i], fresh && i == 0, ends && i == perm_q.size() - 1);
  endtask

  initial begin : rx_side
    int unsigned rx_cycle;
    int unsigned long_left;
    int unsigned seg_left;
    bit          cur;
    int unsigned r;
    out_ready <= 1'b0;
    rx_cycle  = 0;
    long_left = 0;
    seg_left  = 0;
    cur       = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      rx_cycle++;
      if (long_left > 0) begin
        long_left--;
        out_ready <= 1'b0;
      end else if (rx_cycle % 9000 == 1500) begin
        // long hold-off: the block fills and must stall its input
        long_left = 399;
        out_ready <= 1'b0;
      end else if (seg_left > 0) begin
        seg_left--;
        out_ready <= cur;
      end else begin
        cur = !cur;
        r   = $urandom_range(0, 99);
        if (cur)
          seg_left = (r < 85) ? $urandom_range(0, 7) : $urandom_range(40, 150);
        else
          seg_left = (r < 80) ? $urandom_range(0, 2) :
                     (r < 96) ? $urandom_range(4, 14) : $urandom_range(30, 60);
        out_ready <= cur;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned n;
    int unsigned idx;
    int unsigned base;
    int unsigned drain;
    bit          chain_ok;
    in_valid          <= 1'b0;
    in_element        <= '0;
    in_start_new      <= 1'b0;
    in_last_of_prefix <= 1'b0;
    rst_n             <= 1'b0;
    burst_mode        = 1'b0;
    words_sent        = 0;
    chain_ok          = 1'b0;
    base              = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first word without start_new, pops straight away
    send_word(1, 0, 1);
    // descending run, then one push that pops all three
    send_word(3, 1, 0); send_word(2, 0, 0); send_word(1, 0, 1);
    // element zero alone is no violation; a larger value above it is
    send_word(0, 1, 0); send_word(65535, 0, 0);
    // word after a failure is ignored
    send_word(1, 0, 1);
    // repeated values
    send_word(2, 1, 0); send_word(2, 0, 0); send_word(1, 0, 1);
    // alternating bit patterns end in a violation
    send_word(65535, 1, 0); send_word(32768, 0, 0); send_word(21845, 0, 0);
    send_word(43690, 0, 1);
    // single entry left, then an interleaved pop run
    send_word(1, 1, 0); send_word(3, 0, 0); send_word(2, 0, 1);
    // plain order violation
    send_word(2, 1, 0); send_word(3, 0, 1);
    // start_new right after a failed prefix
    send_word(1, 1, 1);

    // fill the stack to its depth with no pops; the next word overflows
    for (int v = 1100; v > 1100 - STACK_DEPTH; v--)
      send_word(v, v == 1100, 0);
    send_word(1, 0, 1);
    send_word(2, 0, 1);

    base = words_sent;
    while (words_sent < base + 500) begin
      burst_mode = ($urandom_range(0, 99) < 20);
      r          = $urandom_range(0, 99);
      n          = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      if (r < 45 || (r < 60 && !chain_ok)) begin
        perm_q.delete();
        build_sortable(1, n);
        if ($urandom_range(0, 9) == 0 && n > 1) begin
          // truncated prefix: final word arrives before the stack drains
          idx = $urandom_range(1, n - 1);
          while (perm_q.size() > idx) void'(perm_q.pop_back());
          send_perm(1, 1);
          chain_ok = 1'b0;
        end else begin
          send_perm(1, 1);
          chain_ok = 1'b1;
          idx      = n + 1;
        end
      end else if (r < 60) begin
        // continue from the previous complete prefix without start_new
        perm_q.delete();
        build_sortable(idx, idx + n - 1);
        send_perm(0, 1);
        idx      = idx + n;
        chain_ok = (idx < 60000);
      end else if (r < 75) begin
        build_shuffled($urandom_range(2, 10));
        send_perm(1, 1);
        chain_ok = 1'b0;
      end else if (r < 85) begin
        perm_q.delete();
        build_sortable(1, n + 1);
        idx = $urandom_range(0, n);
        case ($urandom_range(0, 2))
          0: perm_q[idx] = 0;
          1: perm_q[idx] = perm_q[$urandom_range(0, n)];
          default: perm_q[idx] = $urandom_range(1, 65535);
        endcase
        send_perm(1, 1);
        chain_ok = 1'b0;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          r = $urandom_range(0, 99);
          send_word((r < 50) ? $urandom_range(1, 65535) :
                    (r < 80) ? $urandom_range(1, 8) : $urandom_range(65530, 65535),
                    $urandom_range(0, 3) == 0, $urandom_range(0, 9) < 3);
        end
        chain_ok = 1'b0;
      end
    end
    in_valid <= 1'b0;
    // let the pending count take in the last accepted word
    @(posedge clk);

    drain = 0;
    while (pending != 0 && drain < 50000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
